@@ rtl/sce_pkg.sv @@
// ----------------------------------------------------------------------------
// sce_pkg
// Shared widths, constants, register indexes and record types of the spot
// centroid error unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sce_pkg;

    localparam int PIX_W   = 8;
    localparam int FW_W    = 11;
    localparam int TGT_W   = 10;
    localparam int STEP_W  = 16;
    localparam int ROT_W   = 16;
    localparam int CEN_W   = 10;
    localparam int ERR_W   = 22;
    localparam int COUNT_W = 21;
    localparam int SUM_W   = 30;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [CEN_W-1:0]   CEN_MAX   = {CEN_W{1'b1}};

    // Register file of the configuration port.
    localparam int REG_AW = 5;
    localparam int IDX_W  = 3;
    localparam logic [IDX_W-1:0] REG_THRESHOLD   = 3'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH = 3'd1;
    localparam logic [IDX_W-1:0] REG_TARGET_X    = 3'd2;
    localparam logic [IDX_W-1:0] REG_TARGET_Y    = 3'd3;
    localparam logic [IDX_W-1:0] REG_X_STEPS     = 3'd4;
    localparam logic [IDX_W-1:0] REG_Y_STEPS     = 3'd5;
    localparam logic [IDX_W-1:0] REG_COS         = 3'd6;
    localparam logic [IDX_W-1:0] REG_SIN         = 3'd7;

    localparam logic [PIX_W-1:0]  THRESHOLD_RESET   = 8'd150;
    localparam logic [FW_W-1:0]   FRAME_WIDTH_RESET = 11'd1024;
    localparam logic [STEP_W-1:0] STEPS_RESET       = 16'd256;
    localparam logic [ROT_W-1:0]  COS_RESET         = 16'd16384;
    localparam logic [ROT_W-1:0]  SIN_RESET         = 16'd0;

    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [SUM_W-1:0]   column_sum;
        logic [SUM_W-1:0]   row_sum;
    } t_frame_rec;

    typedef struct packed {
        logic [PIX_W-1:0] threshold;
        logic [FW_W-1:0]  frame_width;
    } t_front_cfg;

    typedef struct packed {
        logic [TGT_W-1:0]        target_x;
        logic [TGT_W-1:0]        target_y;
        logic [STEP_W-1:0]       x_steps;
        logic [STEP_W-1:0]       y_steps;
        logic signed [ROT_W-1:0] cos_rot;
        logic signed [ROT_W-1:0] sin_rot;
    } t_back_cfg;

endpackage

`default_nettype wire

@@ rtl/sce_if.sv @@
// ----------------------------------------------------------------------------
// sce_if
// Valid/ready stream interfaces for pixel input and result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface sce_pix_if;
    logic                        valid;
    logic                        ready;
    logic [sce_pkg::PIX_W-1:0]   pixel;
    logic                        last_of_frame;

    modport source (output valid, output pixel, output last_of_frame, input ready);
    modport sink   (input valid, input pixel, input last_of_frame, output ready);
endinterface

interface sce_res_if;
    logic                             valid;
    logic                             ready;
    logic [sce_pkg::CEN_W-1:0]        centroid_x;
    logic [sce_pkg::CEN_W-1:0]        centroid_y;
    logic signed [sce_pkg::ERR_W-1:0] x_error;
    logic signed [sce_pkg::ERR_W-1:0] y_error;
    logic                             empty_frame;

    modport source (output valid, output centroid_x, output centroid_y, output x_error,
                    output y_error, output empty_frame, input ready);
    modport sink   (input valid, input centroid_x, input centroid_y, input x_error,
                    input y_error, input empty_frame, output ready);
endinterface

`default_nettype wire

@@ rtl/sce_front.sv @@
// ----------------------------------------------------------------------------
// sce_front
// Pixel accumulator: tracks raster position, counts spot pixels and sums
// their coordinates, and pushes one frame record on the last pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module sce_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sce_pkg::t_front_cfg i_cfg,
    sce_pix_if.sink             i_pix,
    output logic                o_push_valid,
    input  logic                i_push_ready,
    output sce_pkg::t_frame_rec o_push_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int EW  = (WW > sce_pkg::FW_W) ? WW : sce_pkg::FW_W;
    localparam int SW1 = sce_pkg::SUM_W + 1;

    logic [CW-1:0]               r_column;
    logic [RW-1:0]               r_row;
    logic [sce_pkg::COUNT_W-1:0] r_count;
    logic [sce_pkg::SUM_W-1:0]   r_csum;
    logic [sce_pkg::SUM_W-1:0]   r_rsum;

    logic [CW-1:0]               n_column;
    logic [RW-1:0]               n_row;
    logic [sce_pkg::COUNT_W-1:0] n_count;
    logic [sce_pkg::SUM_W-1:0]   n_csum;
    logic [sce_pkg::SUM_W-1:0]   n_rsum;

    logic          accept;
    logic          is_spot;
    logic [EW-1:0] fw_ext;
    logic [EW-1:0] w_eff;
    logic [EW-1:0] col_inc;
    logic [SW1-1:0] csum_add;
    logic [SW1-1:0] rsum_add;

    assign i_pix.ready = i_push_ready;
    assign accept      = i_pix.valid && i_push_ready;
    assign is_spot     = i_pix.pixel >= i_cfg.threshold;

    always_comb begin
        fw_ext   = EW'(i_cfg.frame_width);
        w_eff    = ((fw_ext == '0) || (fw_ext > EW'(MAX_WIDTH))) ? EW'(MAX_WIDTH) : fw_ext;
        col_inc  = EW'(r_column) + EW'(1);
        csum_add = {1'b0, r_csum} + SW1'(r_column);
        rsum_add = {1'b0, r_rsum} + SW1'(r_row);

        n_count = r_count;
        n_csum  = r_csum;
        n_rsum  = r_rsum;
        if (is_spot) begin
            if (r_count != sce_pkg::COUNT_MAX) begin
                n_count = r_count + sce_pkg::COUNT_W'(1);
            end
            n_csum = (csum_add > SW1'(sce_pkg::SUM_MAX)) ? sce_pkg::SUM_MAX
                                                        : csum_add[sce_pkg::SUM_W-1:0];
            n_rsum = (rsum_add > SW1'(sce_pkg::SUM_MAX)) ? sce_pkg::SUM_MAX
                                                        : rsum_add[sce_pkg::SUM_W-1:0];
        end

        if (col_inc >= w_eff) begin
            n_column = '0;
            n_row    = (r_row < RW'(MAX_HEIGHT - 1)) ? r_row + RW'(1) : r_row;
        end else begin
            n_column = col_inc[CW-1:0];
            n_row    = r_row;
        end
    end

    assign o_push_valid           = accept && i_pix.last_of_frame;
    assign o_push_data.count      = n_count;
    assign o_push_data.column_sum = n_csum;
    assign o_push_data.row_sum    = n_rsum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
            r_row    <= '0;
            r_count  <= '0;
            r_csum   <= '0;
            r_rsum   <= '0;
        end else if (accept) begin
            if (i_pix.last_of_frame) begin
                r_column <= '0;
                r_row    <= '0;
                r_count  <= '0;
                r_csum   <= '0;
                r_rsum   <= '0;
            end else begin
                r_column <= n_column;
                r_row    <= n_row;
                r_count  <= n_count;
                r_csum   <= n_csum;
                r_rsum   <= n_rsum;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/sce_queue.sv @@
// ----------------------------------------------------------------------------
// sce_queue
// Short register FIFO of frame records between accumulator and solver.
// ----------------------------------------------------------------------------
`default_nettype none

module sce_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push_valid,
    output logic                o_push_ready,
    input  sce_pkg::t_frame_rec i_push_data,
    output logic                o_pop_valid,
    input  logic                i_pop_ready,
    output sce_pkg::t_frame_rec o_pop_data
);

    localparam int AW = (sce_pkg::Q_DEPTH > 1) ? $clog2(sce_pkg::Q_DEPTH) : 1;
    localparam int NW = $clog2(sce_pkg::Q_DEPTH + 1);

    sce_pkg::t_frame_rec r_mem [sce_pkg::Q_DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [NW-1:0] r_fill;

    logic do_push;
    logic do_pop;

    assign o_push_ready = r_fill != NW'(sce_pkg::Q_DEPTH);
    assign o_pop_valid  = r_fill != '0;
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign do_push      = i_push_valid && o_push_ready;
    assign do_pop       = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(sce_pkg::Q_DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(sce_pkg::Q_DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + NW'(1);
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sce_back.sv @@
// ----------------------------------------------------------------------------
// sce_back
// Frame solver: divides the sums by the count one quotient bit per cycle,
// then scales, rotates and saturates the error into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sce_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sce_pkg::t_back_cfg  i_cfg,
    input  logic                i_pop_valid,
    output logic                o_pop_ready,
    input  sce_pkg::t_frame_rec i_pop_data,
    sce_res_if.source           o_res
);

    localparam int CNT_W  = $clog2(sce_pkg::SUM_W);
    localparam int DIFF_W = sce_pkg::TGT_W + 1;
    localparam int PW     = sce_pkg::STEP_W + 1 + DIFF_W;
    localparam int SCL_SH = 8;
    localparam int DXW    = 19;
    localparam int MW     = DXW + sce_pkg::ROT_W;
    localparam int SW     = MW + 1;
    localparam int ROT_SH = 14;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_CENT = 3'd2;
    localparam logic [2:0] S_MUL1 = 3'd3;
    localparam logic [2:0] S_RND1 = 3'd4;
    localparam logic [2:0] S_MUL2 = 3'd5;
    localparam logic [2:0] S_SUM  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    localparam logic signed [SW-1:0] ERR_HI = SW'((1 << (sce_pkg::ERR_W - 1)) - 1);
    localparam logic signed [SW-1:0] ERR_LO = -SW'(1 << (sce_pkg::ERR_W - 1));

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;

    logic [CNT_W-1:0]            r_div_cnt;
    logic [sce_pkg::COUNT_W-1:0] r_den;
    logic [sce_pkg::SUM_W-1:0]   r_num_x;
    logic [sce_pkg::SUM_W-1:0]   r_num_y;
    logic [sce_pkg::COUNT_W-1:0] r_rem_x;
    logic [sce_pkg::COUNT_W-1:0] r_rem_y;
    logic                        r_empty;
    logic [sce_pkg::CEN_W-1:0]   r_cx;
    logic [sce_pkg::CEN_W-1:0]   r_cy;
    logic signed [PW-1:0]        r_px;
    logic signed [PW-1:0]        r_py;
    logic signed [DXW-1:0]       r_dx;
    logic signed [DXW-1:0]       r_dy;
    logic signed [MW-1:0]        r_pxc;
    logic signed [MW-1:0]        r_pys;
    logic signed [MW-1:0]        r_pyc;
    logic signed [MW-1:0]        r_pxs;
    logic signed [SW-1:0]        r_sx;
    logic signed [SW-1:0]        r_sy;

    logic [sce_pkg::COUNT_W:0]   rsh_x;
    logic [sce_pkg::COUNT_W:0]   rsh_y;
    logic                        ge_x;
    logic                        ge_y;
    logic [sce_pkg::COUNT_W:0]   den_ext;
    logic signed [DIFF_W-1:0]    diff_x;
    logic signed [DIFF_W-1:0]    diff_y;
    logic signed [PW-1:0]        px_b;
    logic signed [PW-1:0]        py_b;
    logic signed [SW-1:0]        sx_b;
    logic signed [SW-1:0]        sy_b;
    logic signed [SW-1:0]        qx;
    logic signed [SW-1:0]        qy;
    logic signed [sce_pkg::ERR_W-1:0] ex;
    logic signed [sce_pkg::ERR_W-1:0] ey;
    logic                        load_out;

    assign o_pop_ready = r_state == S_IDLE;
    assign load_out    = (r_state == S_FIN) && (!r_out_valid || o_res.ready);
    assign o_res.valid = r_out_valid;

    always_comb begin
        den_ext = {1'b0, r_den};
        rsh_x   = {r_rem_x, r_num_x[sce_pkg::SUM_W-1]};
        rsh_y   = {r_rem_y, r_num_y[sce_pkg::SUM_W-1]};
        ge_x    = rsh_x >= den_ext;
        ge_y    = rsh_y >= den_ext;

        diff_x = $signed({1'b0, i_cfg.target_x}) - $signed({1'b0, r_cx});
        diff_y = $signed({1'b0, i_cfg.target_y}) - $signed({1'b0, r_cy});

        // Bias negative values so the arithmetic shift truncates toward zero.
        px_b = r_px + $signed({{(PW - SCL_SH){1'b0}}, {SCL_SH{r_px[PW-1]}}});
        py_b = r_py + $signed({{(PW - SCL_SH){1'b0}}, {SCL_SH{r_py[PW-1]}}});
        sx_b = r_sx + $signed({{(SW - ROT_SH){1'b0}}, {ROT_SH{r_sx[SW-1]}}});
        sy_b = r_sy + $signed({{(SW - ROT_SH){1'b0}}, {ROT_SH{r_sy[SW-1]}}});
        qx   = sx_b >>> ROT_SH;
        qy   = sy_b >>> ROT_SH;

        if (qx > ERR_HI) begin
            ex = ERR_HI[sce_pkg::ERR_W-1:0];
        end else if (qx < ERR_LO) begin
            ex = ERR_LO[sce_pkg::ERR_W-1:0];
        end else begin
            ex = qx[sce_pkg::ERR_W-1:0];
        end
        if (qy > ERR_HI) begin
            ey = ERR_HI[sce_pkg::ERR_W-1:0];
        end else if (qy < ERR_LO) begin
            ey = ERR_LO[sce_pkg::ERR_W-1:0];
        end else begin
            ey = qy[sce_pkg::ERR_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_pop_valid) begin
                    n_state = (i_pop_data.count == '0) ? S_FIN : S_DIV;
                end
            end
            S_DIV: begin
                if (r_div_cnt == '0) begin
                    n_state = S_CENT;
                end
            end
            S_CENT: n_state = S_MUL1;
            S_MUL1: n_state = S_RND1;
            S_RND1: n_state = S_MUL2;
            S_MUL2: n_state = S_SUM;
            S_SUM:  n_state = S_FIN;
            S_FIN: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_den     <= i_pop_data.count;
                r_num_x   <= i_pop_data.column_sum;
                r_num_y   <= i_pop_data.row_sum;
                r_rem_x   <= '0;
                r_rem_y   <= '0;
                r_div_cnt <= CNT_W'(sce_pkg::SUM_W - 1);
                r_empty   <= i_pop_data.count == '0;
            end
            S_DIV: begin
                r_rem_x   <= ge_x ? sce_pkg::COUNT_W'(rsh_x - den_ext)
                                  : rsh_x[sce_pkg::COUNT_W-1:0];
                r_rem_y   <= ge_y ? sce_pkg::COUNT_W'(rsh_y - den_ext)
                                  : rsh_y[sce_pkg::COUNT_W-1:0];
                r_num_x   <= {r_num_x[sce_pkg::SUM_W-2:0], ge_x};
                r_num_y   <= {r_num_y[sce_pkg::SUM_W-2:0], ge_y};
                r_div_cnt <= r_div_cnt - CNT_W'(1);
            end
            S_CENT: begin
                r_cx <= (r_num_x > sce_pkg::SUM_W'(sce_pkg::CEN_MAX)) ? sce_pkg::CEN_MAX
                                                                     : r_num_x[sce_pkg::CEN_W-1:0];
                r_cy <= (r_num_y > sce_pkg::SUM_W'(sce_pkg::CEN_MAX)) ? sce_pkg::CEN_MAX
                                                                     : r_num_y[sce_pkg::CEN_W-1:0];
            end
            S_MUL1: begin
                r_px <= $signed({1'b0, i_cfg.x_steps}) * diff_x;
                r_py <= $signed({1'b0, i_cfg.y_steps}) * diff_y;
            end
            S_RND1: begin
                r_dx <= px_b[SCL_SH+DXW-1:SCL_SH];
                r_dy <= py_b[SCL_SH+DXW-1:SCL_SH];
            end
            S_MUL2: begin
                r_pxc <= r_dx * i_cfg.cos_rot;
                r_pys <= r_dy * i_cfg.sin_rot;
                r_pyc <= r_dy * i_cfg.cos_rot;
                r_pxs <= r_dx * i_cfg.sin_rot;
            end
            S_SUM: begin
                r_sx <= SW'(r_pxc) + SW'(r_pys);
                r_sy <= SW'(r_pyc) - SW'(r_pxs);
            end
            default: begin
            end
        endcase

        if (load_out) begin
            o_res.empty_frame <= r_empty;
            o_res.centroid_x  <= r_empty ? '0 : r_cx;
            o_res.centroid_y  <= r_empty ? '0 : r_cy;
            o_res.x_error     <= r_empty ? '0 : ex;
            o_res.y_error     <= r_empty ? '0 : ey;
        end
    end

endmodule

`default_nettype wire

@@ rtl/spot_centroid_error_unit.sv @@
// ----------------------------------------------------------------------------
// spot_centroid_error_unit
// Throughput: one pixel transaction per cycle; the input stalls only while two
//   finished frames wait in the record queue for the solver.
// Result path: the record passes the solver states DIV (bit-serial divider),
//   CENT, MUL1, RND1, MUL2, SUM and FIN; an empty frame skips to FIN.
// Reset (synchronous, active low) clears position, sums, queue and solver and
//   loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module spot_centroid_error_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    sce_pix_if.sink                     i_pix,
    sce_res_if.source                   o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sce_pkg::REG_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    // Configuration registers. Each sits at byte address 4 * index, and a
    // write lands in the access phase of an APB transaction.
    logic [sce_pkg::PIX_W-1:0]  r_threshold;
    logic [sce_pkg::FW_W-1:0]   r_frame_width;
    logic [sce_pkg::TGT_W-1:0]  r_target_x;
    logic [sce_pkg::TGT_W-1:0]  r_target_y;
    logic [sce_pkg::STEP_W-1:0] r_x_steps;
    logic [sce_pkg::STEP_W-1:0] r_y_steps;
    logic [sce_pkg::ROT_W-1:0]  r_cos;
    logic [sce_pkg::ROT_W-1:0]  r_sin;

    logic                        cfg_wr;
    logic [sce_pkg::IDX_W-1:0]   cfg_idx;
    sce_pkg::t_front_cfg         front_cfg;
    sce_pkg::t_back_cfg          back_cfg;

    logic                        q_push_valid;
    logic                        q_push_ready;
    sce_pkg::t_frame_rec         q_push_data;
    logic                        q_pop_valid;
    logic                        q_pop_ready;
    sce_pkg::t_frame_rec         q_pop_data;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[sce_pkg::REG_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= sce_pkg::THRESHOLD_RESET;
            r_frame_width <= sce_pkg::FRAME_WIDTH_RESET;
            r_target_x    <= '0;
            r_target_y    <= '0;
            r_x_steps     <= sce_pkg::STEPS_RESET;
            r_y_steps     <= sce_pkg::STEPS_RESET;
            r_cos         <= sce_pkg::COS_RESET;
            r_sin         <= sce_pkg::SIN_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                sce_pkg::REG_THRESHOLD:   r_threshold   <= pwdata[sce_pkg::PIX_W-1:0];
                sce_pkg::REG_FRAME_WIDTH: r_frame_width <= pwdata[sce_pkg::FW_W-1:0];
                sce_pkg::REG_TARGET_X:    r_target_x    <= pwdata[sce_pkg::TGT_W-1:0];
                sce_pkg::REG_TARGET_Y:    r_target_y    <= pwdata[sce_pkg::TGT_W-1:0];
                sce_pkg::REG_X_STEPS:     r_x_steps     <= pwdata[sce_pkg::STEP_W-1:0];
                sce_pkg::REG_Y_STEPS:     r_y_steps     <= pwdata[sce_pkg::STEP_W-1:0];
                sce_pkg::REG_COS:         r_cos         <= pwdata[sce_pkg::ROT_W-1:0];
                sce_pkg::REG_SIN:         r_sin         <= pwdata[sce_pkg::ROT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read data comes straight from the register file.
    always_comb begin
        case (cfg_idx)
            sce_pkg::REG_THRESHOLD:   prdata = 32'(r_threshold);
            sce_pkg::REG_FRAME_WIDTH: prdata = 32'(r_frame_width);
            sce_pkg::REG_TARGET_X:    prdata = 32'(r_target_x);
            sce_pkg::REG_TARGET_Y:    prdata = 32'(r_target_y);
            sce_pkg::REG_X_STEPS:     prdata = 32'(r_x_steps);
            sce_pkg::REG_Y_STEPS:     prdata = 32'(r_y_steps);
            sce_pkg::REG_COS:         prdata = 32'(r_cos);
            sce_pkg::REG_SIN:         prdata = 32'(r_sin);
            default:                  prdata = '0;
        endcase
    end

    assign front_cfg.threshold   = r_threshold;
    assign front_cfg.frame_width = r_frame_width;
    assign back_cfg.target_x     = r_target_x;
    assign back_cfg.target_y     = r_target_y;
    assign back_cfg.x_steps      = r_x_steps;
    assign back_cfg.y_steps      = r_y_steps;
    assign back_cfg.cos_rot      = $signed(r_cos);
    assign back_cfg.sin_rot      = $signed(r_sin);

    // The front end accumulates one pixel per cycle unless the queue is full;
    // at a frame's last pixel it pushes the final count and sums as one record.
    sce_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (front_cfg),
        .i_pix        (i_pix),
        .o_push_valid (q_push_valid),
        .i_push_ready (q_push_ready),
        .o_push_data  (q_push_data)
    );

    // The record queue lets the next frame stream in while the solver is
    // still dividing and rotating the previous one.
    sce_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (q_push_valid),
        .o_push_ready (q_push_ready),
        .i_push_data  (q_push_data),
        .o_pop_valid  (q_pop_valid),
        .i_pop_ready  (q_pop_ready),
        .o_pop_data   (q_pop_data)
    );

    // The solver turns one record into one result transaction and holds it in
    // its output register until the sink takes it.
    sce_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (back_cfg),
        .i_pop_valid (q_pop_valid),
        .o_pop_ready (q_pop_ready),
        .i_pop_data  (q_pop_data),
        .o_res       (o_res)
    );

    // An empty frame must never carry a centroid or an error.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.empty_frame |->
            o_res.centroid_x == '0 && o_res.centroid_y == '0 &&
            o_res.x_error == '0 && o_res.y_error == '0)
        else $error("empty frame result carries nonzero fields");

    // The last pixel of a frame always leaves a record for the solver.
    a_frame_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.valid && i_pix.ready && i_pix.last_of_frame |=> q_pop_valid)
        else $error("frame end did not produce a queued record");

    // The pixel input only stalls while finished frames are waiting.
    a_stall_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.valid && !i_pix.ready |-> q_pop_valid)
        else $error("pixel input stalled with an empty record queue");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the spot centroid error unit. Pixel streams with
// directed and random content are driven through the input channel, an
// in-bench model predicts the centroid and correction of every frame, and each
// result transaction is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    // The solver still works on a frame after its last pixel; leave margin
    // before touching the registers or ending the run.
    localparam int SOLVER_DRAIN   = 60;
    localparam int RANDOM_PIXELS  = 100;
    localparam int LIMIT_NS       = 5_000_000;
    localparam int ROI_MAX_WIDTH  = 1024;
    localparam int ROI_MAX_ROW    = 1023;
    localparam longint SUM_LIMIT  = longint'(sce_pkg::SUM_MAX);
    localparam longint CNT_LIMIT  = longint'(sce_pkg::COUNT_MAX);
    localparam longint ERR_HI     = 2097151;
    localparam longint ERR_LO     = -2097152;

    // One frame result as the block reports it.
    typedef struct {
        logic [sce_pkg::CEN_W-1:0]        centroid_x;
        logic [sce_pkg::CEN_W-1:0]        centroid_y;
        logic signed [sce_pkg::ERR_W-1:0] x_error;
        logic signed [sce_pkg::ERR_W-1:0] y_error;
        logic                             empty_frame;
    } t_frame_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [sce_pkg::REG_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sce_pix_if pix_bus ();
    sce_res_if res_bus ();

    spot_centroid_error_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Register shadow used by the prediction. It starts at the reset values.
    logic [sce_pkg::PIX_W-1:0]        cfg_threshold = sce_pkg::THRESHOLD_RESET;
    logic [sce_pkg::FW_W-1:0]         cfg_width     = sce_pkg::FRAME_WIDTH_RESET;
    logic [sce_pkg::TGT_W-1:0]        cfg_target_x  = '0;
    logic [sce_pkg::TGT_W-1:0]        cfg_target_y  = '0;
    logic [sce_pkg::STEP_W-1:0]       cfg_x_steps   = sce_pkg::STEPS_RESET;
    logic [sce_pkg::STEP_W-1:0]       cfg_y_steps   = sce_pkg::STEPS_RESET;
    logic signed [sce_pkg::ROT_W-1:0] cfg_cos       = sce_pkg::COS_RESET;
    logic signed [sce_pkg::ROT_W-1:0] cfg_sin       = sce_pkg::SIN_RESET;

    // Raster position and spot accumulators of the frame in flight.
    int unsigned col_pos    = 0;
    int unsigned row_pos    = 0;
    longint      spot_total = 0;
    longint      col_total  = 0;
    longint      row_total  = 0;

    // Predicted frame results, oldest first.
    t_frame_result centroid_queue[$];

    // Run bookkeeping.
    int  fail_count      = 0;
    int  pixel_count     = 0;
    int  frame_count     = 0;
    int  empty_count     = 0;
    int  reg_write_count = 0;

    // Traffic shaping: steady_flow turns off random idling on both sides, and
    // hold_off_cycles makes the receiver refuse results for that many cycles.
    bit  steady_flow     = 1'b0;
    int  hold_off_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

    function automatic longint clamp_error(input longint v);
        if (v > ERR_HI) return ERR_HI;
        if (v < ERR_LO) return ERR_LO;
        return v;
    endfunction

    // Advance the predicted state by one accepted pixel. On the last pixel of
    // a frame the centroid and the rotated correction are queued and the
    // accumulators clear.
    function automatic void accumulate_pixel(input logic [sce_pkg::PIX_W-1:0] pix,
                                             input logic last);
        int unsigned   w;
        t_frame_result r;
        longint        cx, cy, dx, dy, cs, sn;

        w = cfg_width;
        if (w == 0 || w > ROI_MAX_WIDTH) w = ROI_MAX_WIDTH;

        if (pix >= cfg_threshold) begin
            spot_total = (spot_total + 1 > CNT_LIMIT) ? CNT_LIMIT : spot_total + 1;
            col_total  = (col_total + col_pos > SUM_LIMIT) ? SUM_LIMIT : col_total + col_pos;
            row_total  = (row_total + row_pos > SUM_LIMIT) ? SUM_LIMIT : row_total + row_pos;
        end

        if (col_pos + 1 >= w) begin
            col_pos = 0;
            if (row_pos < ROI_MAX_ROW) row_pos++;
        end else begin
            col_pos++;
        end

        if (!last) return;

        if (spot_total == 0) begin
            r = '{centroid_x: '0, centroid_y: '0, x_error: '0, y_error: '0, empty_frame: 1'b1};
            empty_count++;
        end else begin
            cx = col_total / spot_total;
            cy = row_total / spot_total;
            if (cx > 1023) cx = 1023;
            if (cy > 1023) cy = 1023;
            // Signed integer division truncates toward zero at every stage.
            dx = (longint'(cfg_x_steps) * (longint'(cfg_target_x) - cx)) / 256;
            dy = (longint'(cfg_y_steps) * (longint'(cfg_target_y) - cy)) / 256;
            cs = longint'(cfg_cos);
            sn = longint'(cfg_sin);
            r.centroid_x  = cx[sce_pkg::CEN_W-1:0];
            r.centroid_y  = cy[sce_pkg::CEN_W-1:0];
            r.x_error     = sce_pkg::ERR_W'(clamp_error((dx * cs + dy * sn) / 16384));
            r.y_error     = sce_pkg::ERR_W'(clamp_error((dy * cs - dx * sn) / 16384));
            r.empty_frame = 1'b0;
        end
        centroid_queue.push_back(r);
        frame_count++;
        col_pos    = 0;
        row_pos    = 0;
        spot_total = 0;
        col_total  = 0;
        row_total  = 0;
    endfunction

    // Offer one pixel transaction, with random idle cycles ahead of it unless
    // the flow is steady. Valid stays high afterwards so back-to-back pixels
    // follow without a gap.
    task automatic send_pixel(input logic [sce_pkg::PIX_W-1:0] pix, input logic last);
        while (!steady_flow && $urandom_range(99) < 25) begin
            pix_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_bus.valid         <= 1'b1;
        pix_bus.pixel         <= pix;
        pix_bus.last_of_frame <= last;
        @(posedge i_clk);
        while (!pix_bus.ready) @(posedge i_clk);
        accumulate_pixel(pix, last);
        pixel_count++;
    endtask

    // Drop valid, let every predicted result drain, then give the solver time
    // to finish before the registers may be touched.
    task automatic settle_block();
        pix_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (centroid_queue.size() != 0) @(posedge i_clk);
        repeat (SOLVER_DRAIN) @(posedge i_clk);
    endtask

    // One register write through the setup and access phases.
    task automatic write_register(input logic [sce_pkg::IDX_W-1:0] idx,
                                  input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            sce_pkg::REG_THRESHOLD:   cfg_threshold = value[sce_pkg::PIX_W-1:0];
            sce_pkg::REG_FRAME_WIDTH: cfg_width     = value[sce_pkg::FW_W-1:0];
            sce_pkg::REG_TARGET_X:    cfg_target_x  = value[sce_pkg::TGT_W-1:0];
            sce_pkg::REG_TARGET_Y:    cfg_target_y  = value[sce_pkg::TGT_W-1:0];
            sce_pkg::REG_X_STEPS:     cfg_x_steps   = value[sce_pkg::STEP_W-1:0];
            sce_pkg::REG_Y_STEPS:     cfg_y_steps   = value[sce_pkg::STEP_W-1:0];
            sce_pkg::REG_COS:         cfg_cos       = value[sce_pkg::ROT_W-1:0];
            sce_pkg::REG_SIN:         cfg_sin       = value[sce_pkg::ROT_W-1:0];
            default: ;
        endcase
        reg_write_count++;
    endtask

    // Loads the whole register set; the caller makes sure the block is idle.
    task automatic load_setting(input int thr, input int width, input int tx, input int ty,
                                input int xs, input int ys, input int cs, input int sn);
        write_register(sce_pkg::REG_THRESHOLD, 32'(thr));
        write_register(sce_pkg::REG_FRAME_WIDTH, 32'(width));
        write_register(sce_pkg::REG_TARGET_X, 32'(tx));
        write_register(sce_pkg::REG_TARGET_Y, 32'(ty));
        write_register(sce_pkg::REG_X_STEPS, 32'(xs));
        write_register(sce_pkg::REG_Y_STEPS, 32'(ys));
        write_register(sce_pkg::REG_COS, 32'(cs) & 32'hFFFF);
        write_register(sce_pkg::REG_SIN, 32'(sn) & 32'hFFFF);
    endtask

    // A pixel that counts as spot with the given chance under the current
    // threshold; a tenth of the pixels are plain noise.
    function automatic logic [sce_pkg::PIX_W-1:0] pick_pixel(input int unsigned spot_pct);
        if ($urandom_range(9) == 0) return sce_pkg::PIX_W'($urandom_range(255));
        if (cfg_threshold == 0 || $urandom_range(99) < spot_pct)
            return sce_pkg::PIX_W'($urandom_range(255, cfg_threshold));
        return sce_pkg::PIX_W'($urandom_range(cfg_threshold - 1, 0));
    endfunction

    task automatic send_random_frame(input int len, input int unsigned spot_pct);
        for (int i = 0; i < len; i++) send_pixel(pick_pixel(spot_pct), i == len - 1);
    endtask

    // Random frame shape: mostly short, some long, some single pixels, and a
    // spot chance from none at all to every pixel, apart from the noise pixels.
    task automatic send_shaped_frame();
        int          len;
        int unsigned pct;

        case ($urandom_range(19))
            0:       len = 1;
            1,2,3,4: len = $urandom_range(150, 41);
            default: len = $urandom_range(40, 1);
        endcase
        case ($urandom_range(4))
            0: pct = 0;
            1: pct = 5;
            2: pct = 30;
            3: pct = 70;
            default: pct = 100;
        endcase
        send_random_frame(len, pct);
    endtask

    function automatic int pick_extreme16(input int lo, input int hi);
        case ($urandom_range(9))
            0:       return lo;
            1:       return hi;
            default: return int'($urandom_range(hi - lo)) + lo;
        endcase
    endfunction

    task automatic load_random_setting();
        int thr, width;

        case ($urandom_range(9))
            0:       thr = 0;
            1:       thr = 255;
            default: thr = $urandom_range(255);
        endcase
        case ($urandom_range(9))
            0:       width = 0;
            1:       width = $urandom_range(2047, 1025);
            2:       width = 1024;
            default: width = $urandom_range(24, 1);
        endcase
        load_setting(thr, width, $urandom_range(1023), $urandom_range(1023),
                     pick_extreme16(0, 65535), pick_extreme16(0, 65535),
                     pick_extreme16(-32768, 32767), pick_extreme16(-32768, 32767));
    endtask

    // Reset register values: a pixel exactly at the threshold counts, one
    // below does not, then an empty frame and a one-pixel frame.
    task automatic test_reset_defaults();
        send_pixel(8'd150, 1'b0);
        send_pixel(8'd149, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0,   1'b0);
        send_pixel(8'd150, 1'b1);
        send_pixel(8'd149, 1'b0);
        send_pixel(8'd0,   1'b1);
        send_pixel(8'd255, 1'b1);
        settle_block();
    endtask

    // Threshold at zero makes every pixel a spot; at 255 only full white counts.
    task automatic test_threshold_extremes();
        load_setting(0, 4, 3, 1, 256, 256, 16384, 0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd0, 1'b1);
        settle_block();
        write_register(sce_pkg::REG_THRESHOLD, 32'd255);
        send_pixel(8'd254, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd254, 1'b1);
        send_pixel(8'd254, 1'b1);
        settle_block();
    endtask

    // Widths one, zero, 2047 and three; zero and 2047 are taken as 1024.
    task automatic test_frame_width();
        load_setting(100, 1, 2, 2, 256, 256, 16384, 0);
        send_random_frame(6, 100);
        settle_block();
        write_register(sce_pkg::REG_FRAME_WIDTH, 32'd0);
        send_random_frame(5, 60);
        settle_block();
        write_register(sce_pkg::REG_FRAME_WIDTH, 32'd2047);
        send_random_frame(4, 100);
        settle_block();
        write_register(sce_pkg::REG_FRAME_WIDTH, 32'd3);
        send_random_frame(10, 50);
        settle_block();
    endtask

    // Largest scales and offsets at rotation sign extremes, then zero scales.
    task automatic test_correction_extremes();
        load_setting(128, 8, 1023, 1023, 65535, 65535, -32768, 32767);
        send_pixel(8'd200, 1'b1);
        settle_block();
        load_setting(128, 8, 0, 0, 65535, 65535, 32767, -32768);
        send_random_frame(16, 100);
        settle_block();
        load_setting(128, 8, 1023, 0, 0, 0, 16384, 16384);
        send_random_frame(12, 100);
        settle_block();
    endtask

    // A one-pixel-wide frame taller than the row range: the row counter stops
    // at the last row, and only the bottom pixels are spots.
    task automatic test_row_saturation();
        load_setting(200, 1, 0, 0, 65535, 65535, -32768, -32768);
        for (int i = 0; i < 1030; i++)
            send_pixel(i >= 1018 ? 8'd255 : 8'd10, i == 1029);
        settle_block();
    endtask

    // Receiver holds off while short frames keep coming, so the record queue
    // fills and the pixel input must stall until results drain again.
    task automatic test_result_backpressure();
        load_setting(90, 5, 7, 9, 300, 700, 11585, -11585);
        steady_flow     = 1'b1;
        hold_off_cycles = 400;
        for (int f = 0; f < 12; f++) send_random_frame($urandom_range(3, 1), 50);
        steady_flow = 1'b0;
        settle_block();
    endtask

    // A stretch with no idling on either side.
    task automatic test_steady_stream();
        load_random_setting();
        steady_flow = 1'b1;
        for (int f = 0; f < 6; f++) send_shaped_frame();
        steady_flow = 1'b0;
        settle_block();
    endtask

    // Random settings, each followed by a handful of random frames.
    task automatic test_random_frames();
        int start;

        start = pixel_count;
        while (pixel_count - start < RANDOM_PIXELS) begin
            load_random_setting();
            repeat ($urandom_range(8, 3)) send_shaped_frame();
            settle_block();
        end
    endtask

    // Receiver ready: random refusals, a counted hold-off when one is asked
    // for, and always ready during a steady stretch.
    initial begin
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles > 0) begin
                res_bus.ready <= 1'b0;
                hold_off_cycles--;
            end else if (steady_flow) begin
                res_bus.ready <= 1'b1;
            end else begin
                res_bus.ready <= ($urandom_range(99) >= 25);
            end
        end
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Every result transaction is matched against the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_frame_result want;

        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (centroid_queue.size() == 0) begin
                $error("result transaction arrived with no frame outstanding");
                fail_count++;
            end else begin
                want = centroid_queue.pop_front();
                check_field("centroid_x", want.centroid_x, res_bus.centroid_x);
                check_field("centroid_y", want.centroid_y, res_bus.centroid_y);
                check_field("x_error", longint'(want.x_error), longint'(res_bus.x_error));
                check_field("y_error", longint'(want.y_error), longint'(res_bus.y_error));
                check_field("empty_frame", want.empty_frame, res_bus.empty_frame);
            end
        end
    end

    // Main sequence: reset once, then each test in turn, then the verdict.
    initial begin : run_tests
        i_rst_n               <= 1'b0;
        pix_bus.valid         <= 1'b0;
        pix_bus.pixel         <= '0;
        pix_bus.last_of_frame <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_threshold_extremes();
        test_frame_width();
        test_correction_extremes();
        test_row_saturation();
        test_result_backpressure();
        test_steady_stream();
        test_random_frames();
        settle_block();

        $display("Covered %0d pixel transactions in %0d frames, %0d of them empty,",
                 pixel_count, frame_count, empty_count);
        $display("with %0d register writes across threshold, width, target, scale and rotation.",
                 reg_write_count);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ spot_centroid_error_unit.f @@
rtl/sce_pkg.sv
rtl/sce_if.sv
rtl/sce_front.sv
rtl/sce_queue.sv
rtl/sce_back.sv
rtl/spot_centroid_error_unit.sv
tb/tb.sv
